[design/ic2d_pkg.sv]
// ----------------------------------------------------------------------------
// ic2d_pkg: shared types and constants of the 2-D convolution filter
// Beat payloads, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package ic2d_pkg;

   localparam int CSR_ADDR_BITS = 3;

   // mask and line store limits, tied to the field widths below
   localparam int MAX_MASK    = 7;
   localparam int MAX_COLUMNS = 1024;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_COLUMNS = 3'd0,
      CSR_IMAGE_LINES   = 3'd1,
      CSR_MASK_LINES    = 3'd2,
      CSR_MASK_COLUMNS  = 3'd3,
      CSR_LEVEL_OFFSET  = 3'd4,
      CSR_MIN_LEVEL     = 3'd5,
      CSR_MAX_LEVEL     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic               mode;
      logic [5:0]         coef_index;
      logic signed [15:0] coef_value;
      logic [15:0]        pixel;
   } req_type;

   typedef struct packed {
      logic signed [16:0] value;
      logic [15:0]        out_line;
      logic [9:0]         out_column;
      logic               last;
   } rsp_type;

endpackage

[design/image_convolution_2d_clamped.sv]
// ----------------------------------------------------------------------------
// image_convolution_2d_clamped: streaming 2-D convolution with clamp
// Line store, coefficient table and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Window: a pixel beat with a window walks its mask rows times mask columns taps,
// one tap a cycle through the single multiplier (9 taps for a 3x3 mask, 49 for 7x7),
// then drains the product pipeline, rounds and clamps.
// Flow: coefficient beats and pixels without a window do not hold the input off; a
// window holds the input off until its result beat is taken.
// Reset: synchronous, active high; coefficients zero, raster at origin, store kept.
// ----------------------------------------------------------------------------
module image_convolution_2d_clamped
   import ic2d_pkg::*;
#(
   parameter int PIXEL_BITS     = 16,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [16:0]              csr_data
);

   localparam int MB   = $clog2(MAX_MASK);
   localparam int MB1  = $clog2(MAX_MASK + 1);
   localparam int TSB  = MB1 + 1;
   localparam int CB   = $clog2(MAX_COLUMNS);
   localparam int CB1  = $clog2(MAX_COLUMNS + 1);
   localparam int NCOEF = MAX_MASK * MAX_MASK;
   localparam int KB   = $clog2(NCOEF);
   localparam int SB   = $clog2(MAX_MASK * MAX_COLUMNS);
   localparam int ACCB = 48;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ADDR  = 6'b000010,
      ST_MAC   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_ROUND = 6'b010000,
      ST_CLAMP = 6'b100000
   } state_type;

   // configuration registers
   logic [10:0]        cols_cfg_ff;
   logic [15:0]        lines_cfg_ff;
   logic [2:0]         ml_cfg_ff, mc_cfg_ff;
   logic signed [16:0] offset_ff, min_ff, max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff  <= 11'd1024;
         lines_cfg_ff <= 16'd1024;
         ml_cfg_ff    <= 3'd3;
         mc_cfg_ff    <= 3'd3;
         offset_ff    <= '0;
         min_ff       <= '0;
         max_ff       <= 17'sd65535;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_COLUMNS: cols_cfg_ff  <= csr_data[10:0];
            CSR_IMAGE_LINES:   lines_cfg_ff <= csr_data[15:0];
            CSR_MASK_LINES:    ml_cfg_ff    <= csr_data[2:0];
            CSR_MASK_COLUMNS:  mc_cfg_ff    <= csr_data[2:0];
            CSR_LEVEL_OFFSET:  offset_ff    <= csr_data;
            CSR_MIN_LEVEL:     min_ff       <= csr_data;
            CSR_MAX_LEVEL:     max_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // saturated sizes
   logic [CB1-1:0] cols;
   logic [15:0]    lines;
   logic [MB1-1:0] ml, mc;

   always_comb begin
      if (cols_cfg_ff < 11'd3) cols = CB1'(3);
      else if (32'(cols_cfg_ff) > MAX_COLUMNS) cols = CB1'(MAX_COLUMNS);
      else cols = CB1'(cols_cfg_ff);
      lines = (lines_cfg_ff < 16'd3) ? 16'd3 : lines_cfg_ff;
      if (ml_cfg_ff < 3'd3) ml = MB1'(3);
      else if (32'(ml_cfg_ff) > MAX_MASK) ml = MB1'(MAX_MASK);
      else ml = MB1'(ml_cfg_ff);
      if (mc_cfg_ff < 3'd3) mc = MB1'(3);
      else if (32'(mc_cfg_ff) > MAX_MASK) mc = MB1'(MAX_MASK);
      else mc = MB1'(mc_cfg_ff);
   end

   // state
   state_type state_ff, state_in;
   logic [15:0] line_ff;          // raster line of next pixel
   logic [CB-1:0] col_ff;         // raster column of next pixel
   logic [MB-1:0] slot_ff;        // line_ff mod MAX_MASK
   logic [NCOEF-1:0] coef_vld_ff; // entry written since reset
   logic signed [15:0] coef_mem [NCOEF];
   logic [PIXEL_BITS-1:0] store_mem [MAX_MASK*MAX_COLUMNS];

   // window walk
   logic [MB-1:0] r_ff;            // row within mask
   logic [MB-1:0] c_ff;            // column within mask
   logic [MB-1:0] row_slot_ff;     // store slot of current row
   logic [MB-1:0] top_slot_ff;
   logic [CB-1:0] left_ff;
   logic [CB-1:0] tap_col_ff;
   logic          tap_vld_ff, tap_vld2_ff, walk_done_ff;
   logic [15:0]   top_ff;
   logic          last_ff;

   logic [PIXEL_BITS-1:0] pix_rd_ff;
   logic signed [15:0]    coef_rd_ff;
   logic                  coef_ok_ff;
   logic signed [33:0]    prod_ff;
   logic                  prod_vld_ff;
   logic signed [ACCB-1:0] acc_ff;
   logic signed [ACCB-1:0] shifted_ff;
   rsp_type rsp_ff;
   logic    rsp_vld_ff;

   logic accept;
   assign req_stall = (state_ff != ST_IDLE) || rsp_vld_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // window test for the pixel being accepted
   logic        has_win;
   logic [15:0] top_w;
   logic [CB-1:0] left_w;
   logic        end_col, end_line;
   logic [TSB-1:0] top_sum;       // slot + MAX_MASK + 1 - ml, below 2*MAX_MASK
   logic [MB-1:0]  top_slot_w;    // top line mod MAX_MASK
   always_comb begin
      has_win  = (17'(line_ff) + 17'd1 >= 17'(ml)) && (CB1'(col_ff) + CB1'(1) >= CB1'(mc));
      top_w    = line_ff + 16'd1 - 16'(ml);
      left_w   = col_ff + CB'(1) - CB'(mc);
      end_col  = CB1'(col_ff) + CB1'(1) >= cols;
      end_line = 17'(line_ff) + 17'd1 >= 17'(lines);
      top_sum  = TSB'(slot_ff) + TSB'(MAX_MASK + 1) - TSB'(ml);
      top_slot_w = (top_sum >= TSB'(MAX_MASK)) ? MB'(top_sum - TSB'(MAX_MASK))
                                               : MB'(top_sum);
   end

   // tap addressing
   logic [SB-1:0] tap_addr;
   logic [KB-1:0] tap_k;
   assign tap_addr = SB'(row_slot_ff) * SB'(MAX_COLUMNS) + SB'(tap_col_ff);
   assign tap_k    = KB'(KB'(r_ff) * KB'(MAX_MASK) + KB'(c_ff));

   always_ff @(posedge clock) begin
      if (accept && req_data.mode)
         store_mem[SB'(slot_ff) * SB'(MAX_COLUMNS) + SB'(col_ff)] <=
            req_data.pixel[PIXEL_BITS-1:0];
      if (accept && !req_data.mode && 32'(req_data.coef_index) < NCOEF)
         coef_mem[KB'(req_data.coef_index)] <= req_data.coef_value;
      pix_rd_ff  <= store_mem[tap_addr];
      coef_rd_ff <= coef_mem[tap_k];
      coef_ok_ff <= coef_vld_ff[tap_k];
   end

   always_ff @(posedge clock) begin
      if (reset)
         coef_vld_ff <= '0;
      else if (accept && !req_data.mode && 32'(req_data.coef_index) < NCOEF)
         coef_vld_ff[KB'(req_data.coef_index)] <= 1'b1;
   end

   // sequencer
   logic rnd_neg;
   logic signed [ACCB-1:0] rnd_sum;
   logic signed [ACCB-1:0] clamp_v;
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && req_data.mode && has_win) state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_MAC;
         ST_MAC:   if (walk_done_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (!tap_vld_ff && !tap_vld2_ff && !prod_vld_ff) state_in = ST_ROUND;
         ST_ROUND: state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      rnd_sum = acc_ff + (ACCB'(offset_ff) <<< COEF_FRAC_BITS)
                + ACCB'((64'd1 << COEF_FRAC_BITS) >> 1);
      rnd_neg = 1'b0;
      clamp_v = shifted_ff;
      if (shifted_ff < ACCB'(min_ff)) clamp_v = ACCB'(min_ff);
      else if (shifted_ff > ACCB'(max_ff)) clamp_v = ACCB'(max_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         line_ff     <= '0;
         col_ff      <= '0;
         slot_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
         tap_vld_ff  <= 1'b0;
         tap_vld2_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         walk_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_vld_ff && !rsp_stall) rsp_vld_ff <= 1'b0;
         tap_vld2_ff <= tap_vld_ff;
         prod_vld_ff <= tap_vld2_ff;
         if (accept && req_data.mode) begin
            if (end_col) begin
               col_ff <= '0;
               if (end_line) begin
                  line_ff <= '0;
                  slot_ff <= '0;
               end else begin
                  line_ff <= line_ff + 16'd1;
                  slot_ff <= (32'(slot_ff) == MAX_MASK - 1) ? '0 : slot_ff + MB'(1);
               end
            end else begin
               col_ff <= col_ff + CB'(1);
            end
         end
         case (state_ff)
            ST_ADDR: begin
               tap_vld_ff   <= 1'b1;
               walk_done_ff <= 1'b0;
            end
            ST_MAC: begin
               // last tap address is out this cycle, nothing valid after it
               if (!walk_done_ff && 32'(c_ff) + 1 >= 32'(mc) && 32'(r_ff) + 1 >= 32'(ml)) begin
                  walk_done_ff <= 1'b1;
                  tap_vld_ff   <= 1'b0;
               end
            end
            ST_CLAMP: rsp_vld_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept && req_data.mode && has_win) begin
         top_ff      <= top_w;
         left_ff     <= left_w;
         top_slot_ff <= top_slot_w;
         last_ff     <= end_col && end_line;
      end
      case (state_ff)
         ST_ADDR: begin
            r_ff        <= '0;
            c_ff        <= '0;
            row_slot_ff <= top_slot_ff;
            tap_col_ff  <= left_ff;
            acc_ff      <= '0;
         end
         ST_MAC: begin
            if (!walk_done_ff) begin
               if (32'(c_ff) + 1 >= 32'(mc)) begin
                  c_ff        <= '0;
                  tap_col_ff  <= left_ff;
                  r_ff        <= r_ff + MB'(1);
                  row_slot_ff <= (32'(row_slot_ff) == MAX_MASK - 1) ? '0
                                 : row_slot_ff + MB'(1);
               end else begin
                  c_ff       <= c_ff + MB'(1);
                  tap_col_ff <= tap_col_ff + CB'(1);
               end
            end
         end
         ST_ROUND: shifted_ff <= rnd_sum >>> COEF_FRAC_BITS;
         ST_CLAMP: begin
            rsp_ff.value      <= 17'(clamp_v);
            rsp_ff.out_line   <= top_ff + 16'(ml >> 1);
            rsp_ff.out_column <= 10'(32'(left_ff) + 32'(mc >> 1));
            rsp_ff.last       <= last_ff;
         end
         default: ;
      endcase
      // one multiplier, one accumulator
      prod_ff <= (coef_ok_ff ? 34'(coef_rd_ff) : 34'sd0) * $signed({18'd0, pix_rd_ff});
      if (prod_vld_ff) acc_ff <= acc_ff + ACCB'(prod_ff);
      if (rnd_neg) acc_ff <= acc_ff;
   end

   // checks
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while busy");
   a_rsp_from_clamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_CLAMP))
      else $error("result raised outside clamp step");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_walk_taps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !tap_vld_ff)
      else $error("taps in flight while idle");

endmodule
